### rtl/rkse_pkg.sv
// shared types and codes for the range k-th smallest engine
`timescale 1ns / 1ps

package rkse_pkg;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_QUERY = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_AROOT  = 6'b000010,
        S_APATH  = 6'b000100,
        S_QROOT  = 6'b001000,
        S_QNODE  = 6'b010000,
        S_QCHILD = 6'b100000
    } state_t;

endpackage

### rtl/rkse_ram.sv
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps

module rkse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/range_kth_smallest_engine_unit.sv
// top level: persistent segment tree sequencer with root table and node pool
//
// channel  | direction | handshake           | fields
// command  | in        | start, busy         | cmd, value_rank, left_version, right_version, k_rank
// result   | out       | done (one cycle)    | answer_rank, status, versions_held
//
// append: one node pool write per tree level
// query: two dependent node pool reads per level
// refused items answer in the cycle after start, without leaving idle
// reset clears state and counters; unwritten entries never read, node 0 and root 0 forced to zero
// results cannot be stalled; busy stays high until the result strobe
`timescale 1ns / 1ps

module range_kth_smallest_engine_unit #(
    parameter int RANK_BITS    = 10,
    parameter int MAX_VERSIONS = 1024,
    parameter int POOL_DEPTH   = 16384
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   cmd,
    input  logic [RANK_BITS-1:0]                   value_rank,
    input  logic [$clog2(MAX_VERSIONS+1)-1:0]      left_version,
    input  logic [$clog2(MAX_VERSIONS+1)-1:0]      right_version,
    input  logic [$clog2(MAX_VERSIONS+1)-1:0]      k_rank,
    output logic                                   done,
    output logic [RANK_BITS-1:0]                   answer_rank,
    output logic [rkse_pkg::STATUS_W-1:0]          status,
    output logic [$clog2(MAX_VERSIONS+1)-1:0]      versions_held
);

    localparam int VB = $clog2(MAX_VERSIONS + 1);
    localparam int NB = $clog2(POOL_DEPTH);
    localparam int NW = 2 * NB + VB;
    localparam int LW = $clog2(RANK_BITS + 1);
    localparam int SW = NB + 6;

    rkse_pkg::state_t state_reg, state_next;

    logic [VB-1:0]        vc_reg, vc_next;
    logic [NB-1:0]        nc_reg, nc_next;
    logic [NB-1:0]        cur_reg, cur_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [RANK_BITS-1:0] rank_reg, rank_next;
    logic [VB-1:0]        k_reg, k_next;
    logic [RANK_BITS-1:0] ans_reg, ans_next;
    logic [NB-1:0]        ahi_reg, ahi_next;
    logic [NB-1:0]        bhi_reg, bhi_next;
    logic [NB-1:0]        al_reg, al_next;
    logic [NB-1:0]        bl_reg, bl_next;
    logic                 done_reg, done_next;
    logic [RANK_BITS-1:0] answer_reg, answer_next;
    logic [rkse_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                 pz_a_reg, pz_b_reg, rz_a_reg, rz_b_reg;

    logic          pool_we;
    logic [NB-1:0] pool_wa, pool_ra, pool_rb;
    logic [NW-1:0] pool_wd, pool_qa, pool_qb, pa_d, pb_d;
    logic          root_we;
    logic [VB-1:0] root_wa, root_ra, root_rb;
    logic [NB-1:0] root_wd, root_qa, root_qb, ra_d, rb_d;

    logic [VB:0]   lv_x, rv_x, k_x, vc_x;
    logic [SW-1:0] node_sum;
    logic          append_full, query_bad;
    logic [NB-1:0] a_lo, a_hi, b_lo, b_hi, ptr_new, oldc;
    logic [VB-1:0] a_cnt, b_cnt, t_cnt;
    logic          bit_now, go_right;

    rkse_ram #(.WIDTH(NW), .DEPTH(POOL_DEPTH)) u_pool (
        .clk     (clk),
        .we      (pool_we),
        .waddr   (pool_wa),
        .wdata   (pool_wd),
        .raddr_a (pool_ra),
        .rdata_a (pool_qa),
        .raddr_b (pool_rb),
        .rdata_b (pool_qb)
    );

    rkse_ram #(.WIDTH(NB), .DEPTH(MAX_VERSIONS + 1)) u_root (
        .clk     (clk),
        .we      (root_we),
        .waddr   (root_wa),
        .wdata   (root_wd),
        .raddr_a (root_ra),
        .rdata_a (root_qa),
        .raddr_b (root_rb),
        .rdata_b (root_qb)
    );

    // null node and version 0 root read as zero
    assign pa_d = pz_a_reg ? '0 : pool_qa;
    assign pb_d = pz_b_reg ? '0 : pool_qb;
    assign ra_d = rz_a_reg ? '0 : root_qa;
    assign rb_d = rz_b_reg ? '0 : root_qb;

    assign a_lo  = pa_d[NW-1 -: NB];
    assign a_hi  = pa_d[NB+VB-1 -: NB];
    assign a_cnt = pa_d[VB-1:0];
    assign b_lo  = pb_d[NW-1 -: NB];
    assign b_hi  = pb_d[NB+VB-1 -: NB];
    assign b_cnt = pb_d[VB-1:0];
    assign t_cnt = b_cnt - a_cnt;

    assign lv_x = {1'b0, left_version};
    assign rv_x = {1'b0, right_version};
    assign k_x  = {1'b0, k_rank};
    assign vc_x = {1'b0, vc_reg};

    assign node_sum    = SW'(nc_reg) + SW'(RANK_BITS + 1);
    assign append_full = (vc_reg >= VB'(MAX_VERSIONS)) || (node_sum > SW'(POOL_DEPTH - 1));
    assign query_bad   = (lv_x == '0) || (lv_x > rv_x) || (rv_x > vc_x) || (k_x == '0)
                         || (k_x > rv_x - lv_x + (VB+1)'(1));

    assign bit_now  = rank_reg[RANK_BITS-1];
    assign ptr_new  = cur_reg + NB'(1);
    assign oldc     = bit_now ? a_hi : a_lo;
    assign go_right = k_reg > t_cnt;

    always_comb
    begin
        state_next  = state_reg;
        vc_next     = vc_reg;
        nc_next     = nc_reg;
        cur_next    = cur_reg;
        lvl_next    = lvl_reg;
        rank_next   = rank_reg;
        k_next      = k_reg;
        ans_next    = ans_reg;
        ahi_next    = ahi_reg;
        bhi_next    = bhi_reg;
        al_next     = al_reg;
        bl_next     = bl_reg;
        done_next   = 1'b0;
        answer_next = answer_reg;
        status_next = status_reg;
        pool_we     = 1'b0;
        pool_wa     = cur_reg;
        pool_wd     = '0;
        pool_ra     = '0;
        pool_rb     = '0;
        root_we     = 1'b0;
        root_wa     = vc_reg + VB'(1);
        root_wd     = ptr_new;
        root_ra     = vc_reg;
        root_rb     = right_version;
        case (state_reg)
            rkse_pkg::S_IDLE:
            begin
                if (start)
                begin
                    rank_next = value_rank;
                    k_next    = k_rank;
                    ans_next  = '0;
                    lvl_next  = LW'(RANK_BITS);
                    cur_next  = nc_reg;
                    if (cmd == rkse_pkg::CMD_APPEND)
                    begin
                        root_ra = vc_reg;
                        if (append_full)
                        begin
                            done_next   = 1'b1;
                            answer_next = '0;
                            status_next = rkse_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            state_next = rkse_pkg::S_AROOT;
                        end
                    end
                    else
                    begin
                        root_ra = left_version - VB'(1);
                        root_rb = right_version;
                        if (query_bad)
                        begin
                            done_next   = 1'b1;
                            answer_next = '0;
                            status_next = rkse_pkg::STATUS_BAD_QUERY;
                        end
                        else
                        begin
                            state_next = rkse_pkg::S_QROOT;
                        end
                    end
                end
            end
            rkse_pkg::S_AROOT:
            begin
                pool_ra    = ra_d;
                cur_next   = ptr_new;
                root_we    = 1'b1;
                root_wa    = vc_reg + VB'(1);
                root_wd    = ptr_new;
                state_next = rkse_pkg::S_APATH;
            end
            rkse_pkg::S_APATH:
            begin
                pool_we = 1'b1;
                pool_wa = cur_reg;
                if (lvl_reg != '0)
                begin
                    pool_wd   = {bit_now ? a_lo : ptr_new, bit_now ? ptr_new : a_hi,
                                 a_cnt + VB'(1)};
                    pool_ra   = oldc;
                    cur_next  = ptr_new;
                    lvl_next  = lvl_reg - LW'(1);
                    rank_next = rank_reg << 1;
                end
                else
                begin
                    pool_wd     = {a_lo, a_hi, a_cnt + VB'(1)};
                    nc_next     = cur_reg;
                    vc_next     = vc_reg + VB'(1);
                    done_next   = 1'b1;
                    answer_next = '0;
                    status_next = rkse_pkg::STATUS_OK;
                    state_next  = rkse_pkg::S_IDLE;
                end
            end
            rkse_pkg::S_QROOT:
            begin
                pool_ra    = ra_d;
                pool_rb    = rb_d;
                state_next = rkse_pkg::S_QNODE;
            end
            rkse_pkg::S_QNODE:
            begin
                ahi_next   = a_hi;
                bhi_next   = b_hi;
                al_next    = a_lo;
                bl_next    = b_lo;
                pool_ra    = a_lo;
                pool_rb    = b_lo;
                state_next = rkse_pkg::S_QCHILD;
            end
            rkse_pkg::S_QCHILD:
            begin
                ans_next = (ans_reg << 1) | RANK_BITS'(go_right);
                if (go_right)
                begin
                    k_next  = k_reg - t_cnt;
                    pool_ra = ahi_reg;
                    pool_rb = bhi_reg;
                end
                else
                begin
                    pool_ra = al_reg;
                    pool_rb = bl_reg;
                end
                lvl_next = lvl_reg - LW'(1);
                if (lvl_reg == LW'(1))
                begin
                    done_next   = 1'b1;
                    answer_next = ans_next;
                    status_next = rkse_pkg::STATUS_OK;
                    state_next  = rkse_pkg::S_IDLE;
                end
                else
                begin
                    state_next = rkse_pkg::S_QNODE;
                end
            end
            default:
            begin
                state_next = rkse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rkse_pkg::S_IDLE;
            vc_reg     <= '0;
            nc_reg     <= '0;
            done_reg   <= 1'b0;
            answer_reg <= '0;
            status_reg <= rkse_pkg::STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            vc_reg     <= vc_next;
            nc_reg     <= nc_next;
            done_reg   <= done_next;
            answer_reg <= answer_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        lvl_reg  <= lvl_next;
        rank_reg <= rank_next;
        k_reg    <= k_next;
        ans_reg  <= ans_next;
        ahi_reg  <= ahi_next;
        bhi_reg  <= bhi_next;
        al_reg   <= al_next;
        bl_reg   <= bl_next;
        pz_a_reg <= (pool_ra == '0);
        pz_b_reg <= (pool_rb == '0);
        rz_a_reg <= (root_ra == '0);
        rz_b_reg <= (root_rb == '0);
    end

    assign busy          = (state_reg != rkse_pkg::S_IDLE);
    assign done          = done_reg;
    assign answer_rank   = answer_reg;
    assign status        = status_reg;
    assign versions_held = vc_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == rkse_pkg::S_IDLE))
        else $error("result strobe while transaction still running");

    a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= VB'(MAX_VERSIONS))
        else $error("version count beyond limit");

    a_null_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pool_we |-> (pool_wa != '0))
        else $error("null node overwritten");

    a_vc_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (vc_reg == $past(vc_reg)) || (vc_reg == $past(vc_reg) + VB'(1)))
        else $error("version count jumped");

    a_vc_done: assert property (@(posedge clk) disable iff (!rst_n)
        (vc_reg != $past(vc_reg)) |-> done_reg)
        else $error("version count changed without a result");

endmodule

### tb/range_kth_smallest_engine_unit_tb.sv
// self-checking testbench for the range k-th smallest engine: appends, queries, refusals
`timescale 1ns / 1ps

module range_kth_smallest_engine_unit_tb;

    localparam int RB   = 10;
    localparam int MAXV = 1024;
    localparam int PD   = 16384;
    localparam int VW   = 11;

    typedef struct packed {
        logic [RB-1:0]                 answer;
        logic [rkse_pkg::STATUS_W-1:0] stat;
        logic [VW-1:0]                 held;
    } outcome_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          cmd;
    logic [RB-1:0]                 value_rank;
    logic [VW-1:0]                 left_version;
    logic [VW-1:0]                 right_version;
    logic [VW-1:0]                 k_rank;
    logic                          done;
    logic [RB-1:0]                 answer_rank;
    logic [rkse_pkg::STATUS_W-1:0] status;
    logic [VW-1:0]                 versions_held;

    // own copy of the tree
    int unsigned node_lo [PD];
    int unsigned node_hi [PD];
    int unsigned node_cnt [PD];
    int unsigned root_of [MAXV+1];
    int unsigned nodes_used;
    int unsigned held_count;

    outcome_t pending_outcomes[$];
    int       errors;
    int       appends_sent;
    int       queries_sent;
    int       refusals_seen;
    bit       steady;

    range_kth_smallest_engine_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .value_rank(value_rank), .left_version(left_version),
        .right_version(right_version), .k_rank(k_rank), .done(done),
        .answer_rank(answer_rank), .status(status), .versions_held(versions_held)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned clone_node(int unsigned src);
        nodes_used++;
        node_lo[nodes_used]  = node_lo[src];
        node_hi[nodes_used]  = node_hi[src];
        node_cnt[nodes_used] = node_cnt[src] + 1;
        return nodes_used;
    endfunction

    function automatic outcome_t kth_outcome(logic c, logic [RB-1:0] rank,
                                             logic [VW-1:0] lv, logic [VW-1:0] rv,
                                             logic [VW-1:0] kk);
        outcome_t    o;
        int unsigned prev;
        int unsigned cur;
        int unsigned oldc;
        int unsigned newc;
        int unsigned a;
        int unsigned b;
        int unsigned t;
        int unsigned k;
        int unsigned ans;
        o = '0;
        if (c == rkse_pkg::CMD_APPEND)
        begin
            if (held_count >= MAXV || nodes_used + RB + 1 > PD - 1)
                o.stat = rkse_pkg::STATUS_FULL;
            else
            begin
                prev = root_of[held_count];
                cur = clone_node(prev);
                root_of[held_count + 1] = cur;
                for (int d = RB; d > 0; d--)
                begin
                    oldc = rank[d-1] ? node_hi[prev] : node_lo[prev];
                    newc = clone_node(oldc);
                    if (rank[d-1])
                        node_hi[cur] = newc;
                    else
                        node_lo[cur] = newc;
                    prev = oldc;
                    cur = newc;
                end
                held_count++;
                o.stat = rkse_pkg::STATUS_OK;
            end
        end
        else if (lv < 1 || lv > rv || rv > held_count || kk < 1 || kk > rv - lv + 1)
            o.stat = rkse_pkg::STATUS_BAD_QUERY;
        else
        begin
            a = root_of[lv - 1];
            b = root_of[rv];
            k = kk;
            ans = 0;
            for (int d = RB; d > 0; d--)
            begin
                t = node_cnt[node_lo[b]] - node_cnt[node_lo[a]];
                if (k <= t)
                begin
                    a = node_lo[a];
                    b = node_lo[b];
                end
                else
                begin
                    k -= t;
                    ans |= 1 << (d - 1);
                    a = node_hi[a];
                    b = node_hi[b];
                end
            end
            o.answer = ans[RB-1:0];
            o.stat = rkse_pkg::STATUS_OK;
        end
        o.held = held_count[VW-1:0];
        return o;
    endfunction

    task automatic send_item(logic c, logic [RB-1:0] rank, logic [VW-1:0] lv,
                             logic [VW-1:0] rv, logic [VW-1:0] kk);
        int g;
        int r;
        r = $urandom_range(0, 99);
        g = steady ? 0 : (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= c;
        value_rank    <= rank;
        left_version  <= lv;
        right_version <= rv;
        k_rank        <= kk;
        do
            @(posedge clk);
        while (busy);
        pending_outcomes.push_back(kth_outcome(c, rank, lv, rv, kk));
        if (c == rkse_pkg::CMD_APPEND)
            appends_sent++;
        else
            queries_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic send_append(logic [RB-1:0] rank);
        send_item(rkse_pkg::CMD_APPEND, rank, VW'($urandom), VW'($urandom), VW'($urandom));
    endtask

    task automatic send_good_query;
        int unsigned rv;
        int unsigned lv;
        rv = $urandom_range(1, held_count);
        lv = $urandom_range(1, rv);
        send_item(rkse_pkg::CMD_QUERY, RB'($urandom), VW'(lv), VW'(rv),
                  VW'($urandom_range(1, rv - lv + 1)));
    endtask

    task automatic test_empty_tree;
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, 11'd1, 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'h3ff, 11'd0, 11'd0, 11'd0);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'h7ff, 11'h7ff, 11'h7ff);
        drain();
    endtask

    task automatic test_directed;
        send_append(10'd0);
        send_append(10'h3ff);
        send_append(10'd512);
        send_append(10'd511);
        send_append(10'd0);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, 11'd5, 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, 11'd5, 11'd5);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd2, 11'd4, 11'd2);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd5, 11'd5, 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd3, 11'd2, 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd0, 11'd3, 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, 11'd6, 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, 11'd3, 11'd0);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, 11'd3, 11'd4);
        drain();
    endtask

    task automatic test_random_mix(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            steady = (i % 200) > 150;
            r = $urandom_range(0, 99);
            if (r < 45 || held_count == 0)
                send_append(($urandom_range(0, 9) == 0) ? {RB{r[0]}} : RB'($urandom));
            else if (r < 85)
                send_good_query();
            else
                send_item(rkse_pkg::CMD_QUERY, RB'($urandom), VW'($urandom), VW'($urandom),
                          VW'($urandom));
        end
        steady = 0;
        drain();
    endtask

    task automatic test_full_tree;
        while (held_count < MAXV)
            send_append(RB'($urandom));
        repeat (3) send_append(RB'($urandom));
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, VW'(MAXV), 11'd1);
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, VW'(MAXV), VW'(MAXV));
        send_item(rkse_pkg::CMD_QUERY, 10'd0, 11'd1, VW'(MAXV), VW'(MAXV + 1));
        send_item(rkse_pkg::CMD_QUERY, 10'd0, VW'(MAXV), VW'(MAXV), 11'd1);
        repeat (20) send_good_query();
        drain();
    endtask

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: unexpected result answer=%0d status=%0d held=%0d",
                         $time, answer_rank, status, versions_held);
                errors++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (e.stat != rkse_pkg::STATUS_OK)
                    refusals_seen++;
                if (answer_rank !== e.answer)
                begin
                    $display("%0t: answer_rank expected %0d actual %0d", $time, e.answer,
                             answer_rank);
                    errors++;
                end
                if (status !== e.stat)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.stat, status);
                    errors++;
                end
                if (versions_held !== e.held)
                begin
                    $display("%0t: versions_held expected %0d actual %0d", $time, e.held,
                             versions_held);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[range_kth_smallest_engine_unit] ERROR");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < PD; i++)
        begin
            node_lo[i] = 0;
            node_hi[i] = 0;
            node_cnt[i] = 0;
        end
        for (int i = 0; i <= MAXV; i++)
            root_of[i] = 0;
        nodes_used = 0;
        held_count = 0;
        errors = 0;
        appends_sent = 0;
        queries_sent = 0;
        refusals_seen = 0;
        steady = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = rkse_pkg::CMD_APPEND;
        value_rank = '0;
        left_version = '0;
        right_version = '0;
        k_rank = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_tree();
        test_directed();
        test_random_mix(700);
        test_full_tree();
        $display("covered %0d appends and %0d queries, %0d refused or bad transactions",
                 appends_sent, queries_sent, refusals_seen);
        $display("tree filled to %0d versions using %0d pool nodes", held_count, nodes_used);
        if (errors == 0)
            $display("[range_kth_smallest_engine_unit] OK");
        else
            $display("[range_kth_smallest_engine_unit] ERROR");
        $finish;
    end

endmodule
